// ----- hw/rtl/wtok_pkg.sv -----
// Shared types and constants for the word tokenizer / fixed slot packer.
// Used by wtok_ctrl, wtok_dpath and the top level.
package wtok_pkg;

  localparam int STRIDE_DEF = 32;

  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;       // first letter of a word
    logic append;      // word byte inside an open word
    logic close_drop;  // word ended, too long to emit
    logic close_emit;  // word ended, record goes out
    logic emit_adv;    // record byte taken downstream
  } cmd_t;

  typedef struct packed {
    logic in_word;
    logic letter;
    logic word_char;
    logic len_ok;
    logic idx_last;
  } status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

endpackage

// ----- hw/rtl/word_tokenizer_fixed_slot_packer_unit.sv -----
// Word tokenizer with fixed-width record output. A word that ends (by a
// non-word byte or end of text) is sent as STRIDE record bytes from the slot
// memory's read port, one per cycle while slot_stall is low, during which text
// requests are stalled. A word of more than STRIDE bytes is dropped and sends
// nothing. Bytes past the word's length read as zero.
// Depends on wtok_pkg, wtok_ctrl and wtok_dpath.
module word_tokenizer_fixed_slot_packer_unit #(
  parameter int STRIDE = wtok_pkg::STRIDE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic       op,
  input  logic [7:0] text_byte,
  output logic       slot_valid,
  input  logic       slot_stall,
  output logic [7:0] slot_byte,
  output logic       slot_last
);

  wtok_pkg::cmd_t    cmd;
  wtok_pkg::status_t status;

  wtok_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .op         (op),
    .slot_valid (slot_valid),
    .slot_stall (slot_stall),
    .status     (status),
    .cmd        (cmd)
  );

  wtok_dpath #(
    .STRIDE (STRIDE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .cmd       (cmd),
    .status    (status),
    .slot_byte (slot_byte),
    .slot_last (slot_last)
  );

  a_stall_emit: assert property (@(posedge clk) disable iff (rst)
    slot_valid |-> text_stall)
    else $error("text accepted during record output");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (slot_valid && !slot_stall && slot_last) |=> !slot_valid)
    else $error("record continued past last byte");

  a_end_no_rec: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall && !status.in_word) |=> !slot_valid)
    else $error("record started with no open word");

endmodule

// ----- hw/rtl/wtok_ctrl.sv -----
// Controller state machine for the word tokenizer.
// Depends on wtok_pkg; drives wtok_dpath through cmd_t, reads status_t.
module wtok_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_stall,
  input  logic              op,
  output logic              slot_valid,
  input  logic              slot_stall,
  input  wtok_pkg::status_t status,
  output wtok_pkg::cmd_t    cmd
);

  wtok_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtok_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    text_stall = 1'b1;
    slot_valid = 1'b0;
    case (state)
      wtok_pkg::ST_IDLE: begin
        text_stall = 1'b0;
        if (text_valid) begin
          if (op == wtok_pkg::OP_END) begin
            if (status.in_word) begin
              if (status.len_ok) begin
                cmd.close_emit = 1'b1;
                state_next     = wtok_pkg::ST_EMIT;
              end else begin
                cmd.close_drop = 1'b1;
              end
            end
          end else if (!status.in_word) begin
            cmd.start = status.letter;
          end else if (status.word_char) begin
            cmd.append = 1'b1;
          end else if (status.len_ok) begin
            cmd.close_emit = 1'b1;
            state_next     = wtok_pkg::ST_EMIT;
          end else begin
            cmd.close_drop = 1'b1;
          end
        end
      end
      wtok_pkg::ST_EMIT: begin
        slot_valid = 1'b1;
        if (!slot_stall) begin
          cmd.emit_adv = 1'b1;
          if (status.idx_last) begin
            state_next = wtok_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = wtok_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/wtok_dpath.sv -----
// Datapath for the word tokenizer: slot memory, length counter, read index.
// Depends on wtok_pkg; commanded by wtok_ctrl.
module wtok_dpath #(
  parameter int STRIDE = wtok_pkg::STRIDE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        text_byte,
  input  wtok_pkg::cmd_t    cmd,
  output wtok_pkg::status_t status,
  output logic [7:0]        slot_byte,
  output logic              slot_last
);

  localparam int IDX_W = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int LEN_W = $clog2(STRIDE + 2);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(STRIDE);
  localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(STRIDE + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STRIDE - 1);

  logic [7:0]       mem [STRIDE];
  logic [7:0]       rdata;
  logic             in_word;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] idx, idx_next;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  assign wr_en   = cmd.start || (cmd.append && (len < LEN_FULL));
  assign wr_addr = cmd.start ? '0 : len[IDX_W-1:0];

  always_comb begin
    idx_next = idx;
    if (cmd.close_emit) begin
      idx_next = '0;
    end else if (cmd.emit_adv) begin
      idx_next = (idx == IDX_LAST) ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= text_byte;
    end
    rdata <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word <= 1'b0;
      len     <= '0;
      idx     <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.start) begin
        in_word <= 1'b1;
        len     <= LEN_W'(1);
      end else if (cmd.append) begin
        len <= (len < LEN_FULL) ? len + 1'b1 : LEN_OVER;
      end else if (cmd.close_drop) begin
        in_word <= 1'b0;
        len     <= '0;
      end else if (cmd.close_emit) begin
        in_word <= 1'b0;
      end else if (cmd.emit_adv && (idx == IDX_LAST)) begin
        len <= '0;
      end
    end
  end

  assign status.in_word   = in_word;
  assign status.letter    = wtok_pkg::is_letter(text_byte);
  assign status.word_char = wtok_pkg::is_letter(text_byte) ||
                            (text_byte == wtok_pkg::CHAR_HYPHEN);
  assign status.len_ok    = (len <= LEN_FULL);
  assign status.idx_last  = (idx == IDX_LAST);

  assign slot_byte = (LEN_W'(idx) < len) ? rdata : 8'h00;
  assign slot_last = (idx == IDX_LAST);

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_OVER)
    else $error("length counter out of range");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    in_word |-> (idx == '0))
    else $error("read index moved while a word is open");

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.close_emit |=> (!in_word && (idx == '0)))
    else $error("record start left word open");

endmodule

// ----- verif/tb_word_tokenizer_fixed_slot_packer_unit.sv -----
// Testbench for word_tokenizer_fixed_slot_packer_unit: directed and random text
// requests, with the expected record bytes scored against the slot output.
// Depends on wtok_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_word_tokenizer_fixed_slot_packer_unit;

  localparam int SLOT = wtok_pkg::STRIDE_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_FROM = 600;
  localparam int QUIET_TO = 1400;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } text_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rec_byte_t;

  logic       clk;
  logic       rst;
  logic       text_valid;
  logic       text_stall;
  logic       op;
  logic [7:0] text_byte;
  logic       slot_valid;
  logic       slot_stall;
  logic [7:0] slot_byte;
  logic       slot_last;

  text_req_t text_q[$];
  rec_byte_t record_q[$];
  int        n_reqs;
  int        cycles;
  int        mismatches;
  bit        taken;
  rec_byte_t want;
  text_req_t next_req;

  logic       tok_in_word;
  int         tok_len;
  logic [7:0] tok_slot[SLOT];

  word_tokenizer_fixed_slot_packer_unit dut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .op(op),
    .text_byte(text_byte),
    .slot_valid(slot_valid),
    .slot_stall(slot_stall),
    .slot_byte(slot_byte),
    .slot_last(slot_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_alpha(logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return (c < 8'h80) && (folded >= wtok_pkg::CHAR_LOWER_A) &&
           (folded <= wtok_pkg::CHAR_LOWER_Z);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1))
      return wtok_pkg::CHAR_UPPER_A + 8'($urandom_range(25));
    return wtok_pkg::CHAR_LOWER_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_breaker();
    logic [7:0] c;
    c = 8'($urandom);
    while (is_alpha(c) || c == wtok_pkg::CHAR_HYPHEN)
      c = 8'($urandom);
    return c;
  endfunction

  function automatic logic [7:0] rand_nonletter();
    logic [7:0] c;
    c = 8'($urandom);
    while (is_alpha(c))
      c = 8'($urandom);
    return c;
  endfunction

  task automatic push_req(logic o, logic [7:0] c);
    text_req_t r;
    r.op = o;
    r.text_byte = c;
    text_q.push_back(r);
    n_reqs++;
  endtask

  task automatic push_word(int len);
    push_req(wtok_pkg::OP_TEXT, rand_letter());
    for (int i = 1; i < len; i++)
      push_req(wtok_pkg::OP_TEXT,
               ($urandom_range(99) < 15) ? wtok_pkg::CHAR_HYPHEN : rand_letter());
  endtask

  // word ends: full record, or nothing when too long
  task automatic close_word();
    rec_byte_t r;
    if (tok_len <= SLOT) begin
      for (int i = 0; i < SLOT; i++) begin
        r.data = (i < tok_len) ? tok_slot[i] : 8'h00;
        r.last = (i == SLOT - 1);
        record_q.push_back(r);
      end
    end
    tok_in_word = 1'b0;
    tok_len = 0;
  endtask

  task automatic tokenize(logic o, logic [7:0] c);
    if (o == wtok_pkg::OP_END) begin
      if (tok_in_word)
        close_word();
    end else if (!tok_in_word) begin
      if (is_alpha(c)) begin
        tok_in_word = 1'b1;
        tok_slot[0] = c;
        tok_len = 1;
      end
    end else if (!is_alpha(c) && c != wtok_pkg::CHAR_HYPHEN) begin
      close_word();
    end else if (tok_len < SLOT) begin
      tok_slot[tok_len] = c;
      tok_len++;
    end else begin
      tok_len = SLOT + 1;
    end
  endtask

  task automatic report(string msg);
    if (mismatches < 10)
      $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d record bytes outstanding", cycles,
               record_q.size());
      $display("** word_tokenizer_fixed_slot_packer_unit: FAILED **");
      $finish;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    taken = !rst && text_valid && !text_stall;
    if (taken)
      tokenize(op, text_byte);
    if (!rst && slot_valid && !slot_stall) begin
      if (record_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", slot_byte, slot_last));
      end else begin
        want = record_q.pop_front();
        if (slot_byte !== want.data)
          report($sformatf("slot_byte exp %02h got %02h", want.data, slot_byte));
        if (slot_last !== want.last)
          report($sformatf("slot_last exp %0b got %0b", want.last, slot_last));
      end
    end
  end

  // request driver and downstream stall
  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      slot_stall <= 1'b0;
    end else begin
      slot_stall <= !(cycles >= QUIET_FROM && cycles < QUIET_TO) &&
                    ($urandom_range(99) < 10);
      if (!text_valid || taken) begin
        if (text_q.size() != 0 &&
            ((cycles >= QUIET_FROM && cycles < QUIET_TO) || $urandom_range(99) >= 10)) begin
          next_req = text_q.pop_front();
          text_valid <= 1'b1;
          op <= next_req.op;
          text_byte <= next_req.text_byte;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int r;
    int len;
    rst = 1'b1;
    text_valid = 1'b0;
    op = wtok_pkg::OP_TEXT;
    text_byte = 8'h00;
    slot_stall = 1'b0;
    tok_in_word = 1'b0;
    tok_len = 0;
    n_reqs = 0;
    cycles = 0;
    mismatches = 0;
    taken = 1'b0;

    // directed
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_UPPER_A);
    push_req(wtok_pkg::OP_TEXT, 8'h20);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_LOWER_Z);
    push_req(wtok_pkg::OP_END, 8'hFF);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_HYPHEN);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_LOWER_A);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_HYPHEN);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_UPPER_Z);
    push_req(wtok_pkg::OP_TEXT, 8'h80);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_HYPHEN);
    push_req(wtok_pkg::OP_TEXT, "x");
    push_req(wtok_pkg::OP_TEXT, 8'hFF);
    push_req(wtok_pkg::OP_END, 8'h00);
    push_req(wtok_pkg::OP_TEXT, 8'h00);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_UPPER_Z);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_LOWER_Z);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_HYPHEN);
    push_req(wtok_pkg::OP_TEXT, 8'h40);
    push_req(wtok_pkg::OP_TEXT, wtok_pkg::CHAR_LOWER_A);
    push_req(wtok_pkg::OP_TEXT, 8'h5B);
    push_req(wtok_pkg::OP_TEXT, "b");
    push_req(wtok_pkg::OP_TEXT, 8'h60);
    push_req(wtok_pkg::OP_TEXT, "c");
    push_req(wtok_pkg::OP_TEXT, 8'h7B);

    // random: mostly words with separators, some noise
    while (n_reqs < 455) begin
      if ($urandom_range(99) < 80) begin
        r = $urandom_range(99);
        if (r < 4)
          len = SLOT;
        else if (r < 7)
          len = SLOT + 1 + $urandom_range(8);
        else if (r < 9)
          len = SLOT - 1;
        else
          len = 1 + $urandom_range(9);
        push_word(len);
        if ($urandom_range(9) == 0)
          push_req(wtok_pkg::OP_END, 8'($urandom));
        else
          push_req(wtok_pkg::OP_TEXT, rand_breaker());
        repeat ($urandom_range(2))
          push_req(wtok_pkg::OP_TEXT, rand_nonletter());
      end else begin
        repeat (1 + $urandom_range(3))
          push_req(1'($urandom_range(1)), 8'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0 || text_valid)
      @(posedge clk);
    while (record_q.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatches == 0)
      $display("** word_tokenizer_fixed_slot_packer_unit: PASSED **");
    else
      $display("** word_tokenizer_fixed_slot_packer_unit: FAILED **");
    $finish;
  end

endmodule
